### sv/hgbc_pkg.sv
// Shared types, codes and constants for the height grid compensator.
// No dependencies; imported by every module of the block.
`default_nettype none
package hgbc_pkg;

  // defaults for the top-level parameters
  localparam int MAX_SIDE_DEF  = 15;
  localparam int FRAC_BITS_DEF = 16;

  // fixed field widths
  localparam int HEIGHT_W = 20;
  localparam int POS_W    = 21;
  localparam int Z_W      = 24;
  localparam int RAD_W    = 20;
  localparam int EXT_W    = 23;
  localparam int ADDR_W   = 3;

  localparam logic signed [HEIGHT_W-1:0] UNSET_CODE = {1'b1, {(HEIGHT_W-1){1'b0}}};
  localparam logic signed [EXT_W-1:0] H_MAX       = 23'sd524287;
  localparam logic signed [EXT_W-1:0] EXT_NEG_INF = -23'sd4000000;
  localparam logic signed [EXT_W-1:0] EXT_POS_INF = 23'sd4000000;
  localparam logic signed [Z_W-1:0]   Z_MAX       = 24'sh7fffff;
  localparam logic signed [Z_W-1:0]   Z_MIN       = 24'sh800000;

  localparam logic [3:0]       SIDE_RESET = 4'd7;
  localparam logic [RAD_W-1:0] RAD_RESET  = 20'd50000;
  localparam logic [RAD_W-1:0] RAD_MIN    = 20'd1000;

  // register index decoded from paddr[2]
  localparam logic REG_SIDE   = 1'b0;
  localparam logic REG_RADIUS = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_UNSET = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FILL  = 2'd2,
    OP_COMP  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_FILL_SCAN,
    S_FILL_RD,
    S_FILL_EXT,
    S_FILL_MED,
    S_DIV_X,
    S_DIV_Y,
    S_CELL,
    S_RD,
    S_MUL,
    S_SUM,
    S_DONE
  } state_t;

  // linear extrapolation 2*near - far with unset operands mapped to infinities
  function automatic logic signed [EXT_W-1:0] extrap(input logic signed [HEIGHT_W-1:0] nr,
                                                     input logic signed [HEIGHT_W-1:0] fr);
    logic signed [EXT_W-1:0] r;
    if (nr == UNSET_CODE) begin
      r = EXT_NEG_INF;
    end else if (fr == UNSET_CODE) begin
      r = EXT_POS_INF;
    end else begin
      r = (EXT_W'(nr) <<< 1) - EXT_W'(fr);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/hgbc_grid_mem.sv
// Height grid storage: one write port, one registered read port.
// Per-entry valid flops make reset and clear immediate. Uses hgbc_pkg.
`default_nettype none
module hgbc_grid_mem
  import hgbc_pkg::*;
#(
  parameter int DEPTH = MAX_SIDE_DEF * MAX_SIDE_DEF,
  parameter int AW    = $clog2(MAX_SIDE_DEF * MAX_SIDE_DEF)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       clear,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic signed [HEIGHT_W-1:0] wdata,
  input  wire logic [AW-1:0]              raddr,
  output logic signed [HEIGHT_W-1:0]      rdata
);

  logic signed [HEIGHT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           valid;

  // storage array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // registered read, unwritten entries read as unset
  always_ff @(posedge clk) begin
    rdata <= valid[raddr] ? mem[raddr] : UNSET_CODE;
  end

endmodule
`default_nettype wire

### sv/hgbc_div.sv
// Restoring divider, one quotient bit per cycle, for the grid coordinate.
// Uses hgbc_pkg for the divisor width.
`default_nettype none
module hgbc_div
  import hgbc_pkg::*;
#(
  parameter int DW = 40
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DW-1:0]    num,
  input  wire logic [RAD_W-1:0] den,
  output logic                  done,
  output logic [DW-1:0]         quot,
  output logic                  rem_nz
);

  localparam int CW = $clog2(DW + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DW-1:0]    nq;
  logic [RAD_W-1:0] rem;
  logic [RAD_W:0]   trial;
  logic             ge;

  // trial subtract
  always_comb begin
    trial = {rem, nq[DW-1]};
    ge    = trial >= {1'b0, den};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      nq  <= num;
      rem <= '0;
    end else if (busy) begin
      nq  <= {nq[DW-2:0], ge};
      rem <= ge ? RAD_W'(trial - {1'b0, den}) : RAD_W'(trial);
    end
  end

  assign quot   = nq;
  assign rem_nz = |rem;

endmodule
`default_nettype wire

### sv/height_grid_bilinear_compensator_unit.sv
// Top level: sequencer, shared multiplier, grid memory and divider.
// Uses hgbc_pkg, hgbc_grid_mem and hgbc_div.
//
//   channel | signals                                   | direction
//   in      | in_valid/in_ready, op..inverse            | transaction in
//   out     | out_valid/out_ready, z_out, status        | transaction out
//   cfg     | psel/penable/pwrite/paddr/pwdata/prdata   | APB registers
//
// One transaction at a time; in_ready is high only when the sequencer is idle.
// Compensation uses the serial divider, DW = 21+clog2(MAX/2+1)+FRAC bits
// wide (40 at defaults); fill reads corner-entry neighbors via the single read port.
// Reset (rst, synchronous) marks all entries unset at once; a result waiting on
// out_ready does not stop the next transaction from being taken.
`default_nettype none
module height_grid_bilinear_compensator_unit
  import hgbc_pkg::*;
#(
  parameter int MAX_GRID_SIDE       = MAX_SIDE_DEF,
  parameter int COORD_FRACTION_BITS = FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 op,
  input  wire logic [3:0]                 col,
  input  wire logic [3:0]                 row,
  input  wire logic signed [HEIGHT_W-1:0] height_um,
  input  wire logic signed [POS_W-1:0]    pos_x,
  input  wire logic signed [POS_W-1:0]    pos_y,
  input  wire logic signed [Z_W-1:0]      pos_z,
  input  wire logic                       inverse,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [Z_W-1:0]           z_out,
  output logic [1:0]                      status,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ADDR_W-1:0]          paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int F       = COORD_FRACTION_BITS;
  localparam int DEPTH   = MAX_GRID_SIDE * MAX_GRID_SIDE;
  localparam int NW      = $clog2(MAX_GRID_SIDE + 1);
  localparam int AW      = $clog2(DEPTH);
  localparam int HW      = $clog2(MAX_GRID_SIDE / 2 + 1);
  localparam int MW      = POS_W + HW;
  localparam int DW      = MW + F;
  localparam int GW      = NW + F;
  localparam int MAX_ODD = (MAX_GRID_SIDE % 2 == 1) ? MAX_GRID_SIDE : MAX_GRID_SIDE - 1;
  localparam int EPS_RAW = ((1 << F) + 500) / 1000;
  localparam int EPS     = (EPS_RAW < 1) ? 1 : EPS_RAW;
  localparam int SP      = 19;
  localparam int LW      = HEIGHT_W + F + 1;
  localparam int MA      = (F + 3 > 21) ? F + 3 : 21;
  localparam int MB      = F + 2;
  localparam int PW      = MA + MB;
  localparam int AC      = 2 * F + 23;
  localparam int OW      = AC - 2 * F;
  localparam int SW      = Z_W + 2;

  // configuration registers
  logic [3:0]       side_reg;
  logic [RAD_W-1:0] rad_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_reg <= SIDE_RESET;
      rad_reg  <= RAD_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_SIDE:   side_reg <= pwdata[3:0];
        REG_RADIUS: rad_reg  <= pwdata[RAD_W-1:0];
        default:    ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RADIUS) ? 32'(rad_reg) : 32'(side_reg);

  // effective side, half width and radius
  logic [3:0]       n4;
  logic [NW-1:0]    side;
  logic [HW-1:0]    half;
  logic [RAD_W-1:0] rad_eff;
  logic [GW-1:0]    hs;
  logic [GW-1:0]    lim;

  always_comb begin
    n4 = {side_reg[3:1], 1'b1};
    if (n4 < 4'd5) begin
      side = NW'(5);
    end else if (32'(n4) > MAX_ODD) begin
      side = NW'(MAX_ODD);
    end else begin
      side = NW'(n4);
    end
    half    = HW'(side >> 1);
    rad_eff = (rad_reg < RAD_MIN) ? RAD_MIN : rad_reg;
    hs      = GW'({half, {F{1'b0}}});
    lim     = hs - GW'(EPS);
  end

  // state and captured transaction
  state_t                     state, state_next;
  op_t                        op_q;
  logic [3:0]                 col_q, row_q;
  logic signed [HEIGHT_W-1:0] hgt_q;
  logic signed [POS_W-1:0]    px_q, py_q;
  logic signed [Z_W-1:0]      pz_q;
  logic                       inv_q;

  // result register
  logic signed [Z_W-1:0] res_z;
  logic [1:0]            res_st;

  // memory interface
  logic                       mem_clear, mem_we;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic signed [HEIGHT_W-1:0] mem_wdata, mem_rdata;

  // divider interface
  logic          div_start, div_done, div_rnz, neg_q;
  logic [DW-1:0] div_num, div_quot;

  // fill sequencer
  logic [HW-1:0]              fy, fx;
  logic [1:0]                 fq;
  logic [2:0]                 fk;
  logic signed [HEIGHT_W-1:0] fv [6];
  logic signed [EXT_W-1:0]    ea, eb, ec;

  // compensation datapath
  logic [GW-1:0]              gx, gy;
  logic [AW-1:0]              base;
  logic [2:0]                 rk;
  logic signed [HEIGHT_W-1:0] zq [4];
  logic [3:0]                 ms;
  logic signed [PW-1:0]       prod;
  logic signed [LW-1:0]       lsum, rsum;
  logic signed [AC-1:0]       acc;

  hgbc_grid_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .clear (mem_clear),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  hgbc_div #(.DW(DW)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (rad_eff),
    .done   (div_done),
    .quot   (div_quot),
    .rem_nz (div_rnz)
  );

  // fill geometry: target and the neighbor read for step fk
  logic [NW-1:0]  tc, tr, cc, rr;
  logic [1:0]     kx, ky, offx, offy;
  logic           dxv, dyv, fill_last, fill_skip, scan_skip;
  logic [AW-1:0]  fill_raddr, fill_taddr, write_addr;

  always_comb begin
    tc  = fq[0] ? NW'(half) + NW'(fx) : NW'(half) - NW'(fx);
    tr  = fq[1] ? NW'(half) + NW'(fy) : NW'(half) - NW'(fy);
    dxv = fx > HW'(1);
    dyv = fy > HW'(1);
    case (fk)
      3'd1:    begin kx = 2'd1; ky = 2'd0; end
      3'd2:    begin kx = 2'd2; ky = 2'd0; end
      3'd3:    begin kx = 2'd0; ky = 2'd1; end
      3'd4:    begin kx = 2'd0; ky = 2'd2; end
      3'd5:    begin kx = 2'd1; ky = 2'd1; end
      3'd6:    begin kx = 2'd2; ky = 2'd2; end
      default: begin kx = 2'd0; ky = 2'd0; end
    endcase
    offx = dxv ? kx : 2'd0;
    offy = dyv ? ky : 2'd0;
    cc   = fq[0] ? tc - NW'(offx) : tc + NW'(offx);
    rr   = fq[1] ? tr - NW'(offy) : tr + NW'(offy);
    fill_raddr = AW'(32'(rr) * 32'(side) + 32'(cc));
    fill_taddr = AW'(32'(tr) * 32'(side) + 32'(tc));
    write_addr = AW'(32'(row_q) * 32'(side) + 32'(col_q));
    fill_last  = (fq == 2'd3) && (fx == half) && (fy == half);
    scan_skip  = ((HW + 1)'(fx) + (HW + 1)'(fy)) < (HW + 1)'(3);
    fill_skip  = (fk == 3'd1) && (mem_rdata != UNSET_CODE);
  end

  // median of the three extrapolations, saturated
  logic signed [EXT_W-1:0] mn_ab, mx_ab, mn2, med, med_sat;

  always_comb begin
    mn_ab = (ea < eb) ? ea : eb;
    mx_ab = (ea > eb) ? ea : eb;
    mn2   = (mx_ab < ec) ? mx_ab : ec;
    med   = (mn_ab > mn2) ? mn_ab : mn2;
    if (med > H_MAX) begin
      med_sat = H_MAX;
    end else if (med < -H_MAX) begin
      med_sat = -H_MAX;
    end else begin
      med_sat = med;
    end
  end

  // divider operand: |pos| * half, scaled by 2^F
  logic signed [POS_W-1:0] dpos;
  logic [POS_W-1:0]        dmag;
  logic [MW-1:0]           dprod;

  always_comb begin
    dpos    = (state == S_EXEC) ? px_q : py_q;
    dmag    = dpos[POS_W-1] ? POS_W'(-dpos) : POS_W'(dpos);
    dprod   = MW'(dmag) * MW'(half);
    div_num = {dprod, {F{1'b0}}};
  end

  // clamp and offset of the divider result
  logic [DW:0]   qa;
  logic [GW-1:0] qmag, gnew;

  always_comb begin
    qa   = (DW + 1)'(div_quot) + (DW + 1)'(neg_q & div_rnz);
    qmag = (qa > (DW + 1)'(lim)) ? lim : GW'(qa);
    gnew = neg_q ? hs - qmag : hs + qmag;
  end

  // cell indices and ratios
  logic [NW-1:0] cx, cy;
  logic [F-1:0]  rx, ry;
  logic [F:0]    wx0, wy0;
  logic [AW-1:0] comp_raddr;

  always_comb begin
    cx  = gx[GW-1:F];
    cy  = gy[GW-1:F];
    rx  = gx[F-1:0];
    ry  = gy[F-1:0];
    wx0 = {1'b1, {F{1'b0}}} - {1'b0, rx};
    wy0 = {1'b1, {F{1'b0}}} - {1'b0, ry};
    case (rk)
      3'd1:    comp_raddr = base + AW'(side);
      3'd2:    comp_raddr = base + AW'(1);
      3'd3:    comp_raddr = base + AW'(side) + AW'(1);
      default: comp_raddr = base;
    endcase
  end

  // shared multiplier operand select
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic [3:0]           pm;

  always_comb begin
    pm = ms - 4'd1;
    case (ms)
      4'd0:    begin mul_a = MA'(zq[0]); mul_b = MB'($signed({1'b0, wy0})); end
      4'd1:    begin mul_a = MA'(zq[1]); mul_b = MB'($signed({1'b0, ry})); end
      4'd2:    begin mul_a = MA'(zq[2]); mul_b = MB'($signed({1'b0, wy0})); end
      4'd3:    begin mul_a = MA'(zq[3]); mul_b = MB'($signed({1'b0, ry})); end
      4'd4:    begin
        mul_a = MA'($signed({1'b0, lsum[SP-1:0]}));
        mul_b = MB'($signed({1'b0, wx0}));
      end
      4'd5:    begin mul_a = MA'(lsum >>> SP); mul_b = MB'($signed({1'b0, wx0})); end
      4'd6:    begin
        mul_a = MA'($signed({1'b0, rsum[SP-1:0]}));
        mul_b = MB'($signed({1'b0, rx}));
      end
      4'd7:    begin mul_a = MA'(rsum >>> SP); mul_b = MB'($signed({1'b0, rx})); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // final rounding and Z adjustment
  logic                    any_unset;
  logic signed [AC-1:0]    acc_rnd;
  logic signed [OW-1:0]    off;
  logic signed [SW-1:0]    zsum;
  logic signed [Z_W-1:0]   zsat;

  always_comb begin
    any_unset = (zq[0] == UNSET_CODE) || (zq[1] == UNSET_CODE) ||
                (zq[2] == UNSET_CODE) || (zq[3] == UNSET_CODE);
    acc_rnd   = acc + (AC'(1) <<< (2 * F - 1));
    off       = acc_rnd[AC-1:2*F];
    zsum      = inv_q ? SW'(pz_q) - SW'(off) : SW'(pz_q) + SW'(off);
    if (zsum > SW'(Z_MAX)) begin
      zsat = Z_MAX;
    end else if (zsum < SW'(Z_MIN)) begin
      zsat = Z_MIN;
    end else begin
      zsat = Z_W'(zsum);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        unique case (op_q)
          OP_WRITE, OP_CLEAR: state_next = S_DONE;
          OP_FILL:            state_next = S_FILL_SCAN;
          OP_COMP:            state_next = S_DIV_X;
          default:            state_next = S_DONE;
        endcase
      end
      S_FILL_SCAN: begin
        if (!scan_skip) begin
          state_next = S_FILL_RD;
        end else if (fill_last) begin
          state_next = S_DONE;
        end
      end
      S_FILL_RD: begin
        if (fill_skip) begin
          state_next = fill_last ? S_DONE : S_FILL_SCAN;
        end else if (fk == 3'd7) begin
          state_next = S_FILL_EXT;
        end
      end
      S_FILL_EXT:  state_next = S_FILL_MED;
      S_FILL_MED:  state_next = fill_last ? S_DONE : S_FILL_SCAN;
      S_DIV_X:     if (div_done) state_next = S_DIV_Y;
      S_DIV_Y:     if (div_done) state_next = S_CELL;
      S_CELL:      state_next = S_RD;
      S_RD:        if (rk == 3'd4) state_next = S_MUL;
      S_MUL:       if (ms == 4'd8) state_next = S_SUM;
      S_SUM:       state_next = S_DONE;
      S_DONE:      if (!out_valid || out_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = (state == S_IDLE);
    mem_clear = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = write_addr;
    mem_wdata = hgt_q;
    mem_raddr = comp_raddr;
    div_start = 1'b0;
    unique case (state)
      S_EXEC: begin
        mem_clear = (op_q == OP_CLEAR);
        mem_we    = (op_q == OP_WRITE) && (32'(col_q) < 32'(side)) &&
                    (32'(row_q) < 32'(side));
        div_start = (op_q == OP_COMP);
      end
      S_FILL_RD: mem_raddr = fill_raddr;
      S_FILL_MED: begin
        mem_waddr = fill_taddr;
        mem_wdata = HEIGHT_W'(med_sat);
        mem_we    = (med != EXT_NEG_INF);
      end
      S_DIV_X: div_start = div_done;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      z_out  <= res_z;
      status <= res_st;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // capture the transaction
    if (state == S_IDLE && in_valid) begin
      op_q  <= op_t'(op);
      col_q <= col;
      row_q <= row;
      hgt_q <= height_um;
      px_q  <= pos_x;
      py_q  <= pos_y;
      pz_q  <= pos_z;
      inv_q <= inverse;
    end

    if (div_start) begin
      neg_q <= dpos[POS_W-1];
    end

    case (state)
      S_EXEC: begin
        res_z  <= '0;
        res_st <= ST_OK;
        if (op_q == OP_WRITE && !((32'(col_q) < 32'(side)) && (32'(row_q) < 32'(side)))) begin
          res_st <= ST_RANGE;
        end
        fy <= '0;
        fx <= '0;
        fq <= '0;
      end
      S_FILL_SCAN: begin
        fk <= '0;
      end
      S_FILL_RD: begin
        fk <= fk + 3'd1;
        // step 1 returns the target itself; neighbors follow from step 2
        if (fk >= 3'd2) begin
          fv[3'(fk - 3'd2)] <= mem_rdata;
        end
      end
      S_FILL_EXT: begin
        ea <= extrap(fv[0], fv[1]);
        eb <= extrap(fv[2], fv[3]);
        ec <= extrap(fv[4], fv[5]);
      end
      S_DIV_X: begin
        if (div_done) gx <= gnew;
      end
      S_DIV_Y: begin
        if (div_done) gy <= gnew;
      end
      S_CELL: begin
        base <= AW'(32'(cy) * 32'(side) + 32'(cx));
        rk   <= '0;
      end
      S_RD: begin
        rk <= rk + 3'd1;
        ms <= '0;
        if (rk != 3'd0) begin
          zq[2'(rk - 3'd1)] <= mem_rdata;
        end
      end
      S_MUL: begin
        ms   <= ms + 4'd1;
        prod <= mul_a * mul_b;
        if (ms != 4'd0) begin
          case (pm)
            4'd0:    lsum <= LW'(prod);
            4'd1:    lsum <= lsum + LW'(prod);
            4'd2:    rsum <= LW'(prod);
            4'd3:    rsum <= rsum + LW'(prod);
            4'd4:    acc  <= AC'(prod);
            4'd5:    acc  <= acc + (AC'(prod) <<< SP);
            4'd6:    acc  <= acc + AC'(prod);
            4'd7:    acc  <= acc + (AC'(prod) <<< SP);
            default: ;
          endcase
        end
      end
      S_SUM: begin
        res_z  <= any_unset ? pz_q : zsat;
        res_st <= any_unset ? ST_UNSET : ST_OK;
      end
      default: ;
    endcase

    // step the corner walk
    if ((state == S_FILL_SCAN && scan_skip) || (state == S_FILL_RD && fill_skip) ||
        state == S_FILL_MED) begin
      fq <= fq + 2'd1;
      if (fq == 2'd3) begin
        if (fx == half) begin
          fx <= '0;
          fy <= fy + HW'(1);
        end else begin
          fx <= fx + HW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire
